// ----- rtl/gwr_pkg.sv -----
// Shared types and constants of the grid wavefront router.
`default_nettype none
package gwr_pkg;

   localparam int GRID_SIZE_DEF = 8;
   localparam int MAX_RESULTS   = 63;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_ROUTE = 1'b1;

   localparam logic [1:0] DIR_MINUS_X = 2'd0;
   localparam logic [1:0] DIR_PLUS_X  = 2'd1;
   localparam logic [1:0] DIR_MINUS_Y = 2'd2;
   localparam logic [1:0] DIR_PLUS_Y  = 2'd3;

   typedef struct packed {
      logic       kind;
      logic [2:0] cell_x;
      logic [2:0] cell_y;
      logic       cell_full;
      logic [2:0] start_x;
      logic [2:0] start_y;
      logic [2:0] goal_x;
      logic [2:0] goal_y;
   } req_word_type;

   typedef struct packed {
      logic       reachable;
      logic [5:0] path_length;
      logic [1:0] step_dir;
      logic       last;
   } rsp_word_type;

   typedef struct packed {
      logic       load;
      logic       flood;
      logic       trace;
      logic       fix;
      logic       wr_en;
      logic       wr_val;
      logic [1:0] dir;
      logic [2:0] wx;
      logic [2:0] wy;
      logic [2:0] sx;
      logic [2:0] sy;
      logic [2:0] gx;
      logic [2:0] gy;
   } cell_ctl_type;

endpackage
`default_nettype wire

// ----- rtl/gwr_cell.sv -----
// One grid cell: occupancy, wave distance and trace token.
`default_nettype none
module gwr_cell #(
   parameter int X  = 0,
   parameter int Y  = 0,
   parameter int DW = 7
) (
   input  wire                       clock,
   input  wire                       reset,
   input  gwr_pkg::cell_ctl_type     ctl,
   input  wire  [DW-1:0]             lvl_next,
   input  wire  [DW-1:0]             dist_prev,
   input  wire  [3:0]                nb_reach,
   input  wire  [3:0][DW-1:0]        nb_dist,
   input  wire  [3:0]                nb_match,
   output logic                      reached,
   output logic [DW-1:0]             dist_val,
   output logic                      match,
   output logic                      grew,
   output logic                      start_hit
);

   logic          occ_ff, occ_in;
   logic          cur_ff, cur_in;
   logic [DW-1:0] dist_ff, dist_in;
   logic          is_w, is_s, is_g, free;

   assign is_w = (int'(ctl.wx) == X) && (int'(ctl.wy) == Y);
   assign is_s = (int'(ctl.sx) == X) && (int'(ctl.sy) == Y);
   assign is_g = (int'(ctl.gx) == X) && (int'(ctl.gy) == Y);
   assign free = !occ_ff || is_s;

   assign grew      = ctl.flood && (dist_ff == '0) && free && (|nb_reach);
   assign start_hit = grew && is_s;
   assign match     = ctl.trace && cur_ff && (nb_dist[ctl.dir] == dist_prev);
   assign reached   = (dist_ff != '0);
   assign dist_val  = dist_ff;

   always_comb begin
      occ_in = occ_ff;
      if (ctl.wr_en && is_w) begin
         occ_in = ctl.wr_val;
      end
      if (ctl.fix && is_s) begin
         occ_in = 1'b0;
      end
      if (ctl.fix && is_g) begin
         occ_in = 1'b1;
      end
   end

   always_comb begin
      dist_in = dist_ff;
      if (ctl.load) begin
         dist_in = (is_g && !is_s) ? DW'(1) : '0;
      end else if (grew) begin
         dist_in = lvl_next;
      end
   end

   always_comb begin
      cur_in = cur_ff;
      if (ctl.load) begin
         cur_in = is_s;
      end else if (ctl.trace) begin
         cur_in = match ? 1'b0 : (cur_ff | nb_match[ctl.dir ^ 2'd1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
         cur_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
         cur_ff <= cur_in;
      end
      dist_ff <= dist_in;
   end

endmodule
`default_nettype wire

// ----- rtl/grid_wavefront_router_unit.sv -----
// Top level of the grid wavefront router: cell array and sequencer.
//
// Usage: present a word on req_word with start high; it is taken when busy is
// low. A write word (kind 0) sets one cell's occupancy and gives no
// result. A route word (kind 1) loads the cell array, then spreads the
// wave one distance level per cycle across all cells at once, then moves a
// trace token one try per cycle, each try testing one direction in the
// rotation minus x, plus x, minus y, plus y. Every taken step is a result
// word on rsp_word, marked by rsp_strobe for one cycle; the final one has
// last set, and in that cycle the start cell is freed and the goal occupied.
// An unreachable query gives one word with reachable clear.
// busy stays high while a route word is loaded, flooded and traced.
// Reset clears the occupancy of every cell and the sequencer. The receiver
// cannot stall: a result is gone after its strobe cycle.
`default_nettype none
module grid_wavefront_router_unit #(
   parameter int GRID_SIZE = gwr_pkg::GRID_SIZE_DEF
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    start,
   output logic                   busy,
   input  gwr_pkg::req_word_type  req_word,
   output logic                   rsp_strobe,
   output gwr_pkg::rsp_word_type  rsp_word
);

   localparam int NC = GRID_SIZE * GRID_SIZE;
   localparam int DW = $clog2(NC + 2);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_LOAD  = 4'b0010,
      S_FLOOD = 4'b0100,
      S_TRACE = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   logic [DW-1:0]         lvl_ff, lvl_in, trk_ff, trk_in;
   logic [5:0]            len_ff, len_in, n_ff, n_in;
   logic [1:0]            dir_ff, dir_in;
   logic [2:0]            sx_ff, sy_ff, gx_ff, gy_ff;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   gwr_pkg::rsp_word_type rsp_word_ff, rsp_word_in;
   gwr_pkg::cell_ctl_type ctl;

   logic                  accept, in_range, step_last;
   logic                  any_match, any_grew, any_hit;
   logic [DW-1:0]         lvl_next, dist_prev;
   logic [NC-1:0]         reach_w, match_w, grew_w, hit_w;
   logic [DW-1:0]         dist_w [NC];

   assign accept    = start && (state_ff == S_IDLE);
   assign busy      = (state_ff != S_IDLE);
   assign lvl_next  = lvl_ff + DW'(1);
   assign dist_prev = trk_ff - DW'(1);
   assign any_match = |match_w;
   assign any_grew  = |grew_w;
   assign any_hit   = |hit_w;
   assign step_last = (trk_ff == DW'(2)) || (n_ff == 6'(gwr_pkg::MAX_RESULTS - 1));
   assign in_range  = (int'(req_word.start_x) < GRID_SIZE)
                   && (int'(req_word.start_y) < GRID_SIZE)
                   && (int'(req_word.goal_x) < GRID_SIZE)
                   && (int'(req_word.goal_y) < GRID_SIZE);

   always_comb begin
      ctl        = '0;
      ctl.load   = (state_ff == S_LOAD);
      ctl.flood  = (state_ff == S_FLOOD);
      ctl.trace  = (state_ff == S_TRACE);
      ctl.fix    = (state_ff == S_TRACE) && any_match && step_last;
      ctl.wr_en  = accept && (req_word.kind == gwr_pkg::KIND_WRITE);
      ctl.wr_val = req_word.cell_full;
      ctl.dir    = dir_ff;
      ctl.wx     = req_word.cell_x;
      ctl.wy     = req_word.cell_y;
      ctl.sx     = sx_ff;
      ctl.sy     = sy_ff;
      ctl.gx     = gx_ff;
      ctl.gy     = gy_ff;
   end

   for (genvar gx = 0; gx < GRID_SIZE; gx++) begin : g_col
      for (genvar gy = 0; gy < GRID_SIZE; gy++) begin : g_row
         localparam int I = gx * GRID_SIZE + gy;
         logic [3:0]         nb_reach, nb_match;
         logic [3:0][DW-1:0] nb_dist;

         if (gx > 0) begin : g_mx
            assign nb_reach[0] = reach_w[I-GRID_SIZE];
            assign nb_match[0] = match_w[I-GRID_SIZE];
            assign nb_dist[0]  = dist_w[I-GRID_SIZE];
         end else begin : g_mx0
            assign nb_reach[0] = 1'b0;
            assign nb_match[0] = 1'b0;
            assign nb_dist[0]  = '0;
         end
         if (gx < GRID_SIZE - 1) begin : g_px
            assign nb_reach[1] = reach_w[I+GRID_SIZE];
            assign nb_match[1] = match_w[I+GRID_SIZE];
            assign nb_dist[1]  = dist_w[I+GRID_SIZE];
         end else begin : g_px0
            assign nb_reach[1] = 1'b0;
            assign nb_match[1] = 1'b0;
            assign nb_dist[1]  = '0;
         end
         if (gy > 0) begin : g_my
            assign nb_reach[2] = reach_w[I-1];
            assign nb_match[2] = match_w[I-1];
            assign nb_dist[2]  = dist_w[I-1];
         end else begin : g_my0
            assign nb_reach[2] = 1'b0;
            assign nb_match[2] = 1'b0;
            assign nb_dist[2]  = '0;
         end
         if (gy < GRID_SIZE - 1) begin : g_py
            assign nb_reach[3] = reach_w[I+1];
            assign nb_match[3] = match_w[I+1];
            assign nb_dist[3]  = dist_w[I+1];
         end else begin : g_py0
            assign nb_reach[3] = 1'b0;
            assign nb_match[3] = 1'b0;
            assign nb_dist[3]  = '0;
         end

         gwr_cell #(.X(gx), .Y(gy), .DW(DW)) u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctl       (ctl),
            .lvl_next  (lvl_next),
            .dist_prev (dist_prev),
            .nb_reach  (nb_reach),
            .nb_dist   (nb_dist),
            .nb_match  (nb_match),
            .reached   (reach_w[I]),
            .dist_val  (dist_w[I]),
            .match     (match_w[I]),
            .grew      (grew_w[I]),
            .start_hit (hit_w[I])
         );
      end
   end

   always_comb begin
      state_in      = state_ff;
      lvl_in        = lvl_ff;
      trk_in        = trk_ff;
      len_in        = len_ff;
      n_in          = n_ff;
      dir_in        = dir_ff;
      rsp_strobe_in = 1'b0;
      rsp_word_in   = '0;
      rsp_word_in.last = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && (req_word.kind == gwr_pkg::KIND_ROUTE)) begin
               if (in_range) begin
                  state_in = S_LOAD;
               end else begin
                  rsp_strobe_in = 1'b1;
               end
            end
         end
         S_LOAD: begin
            lvl_in   = DW'(1);
            state_in = S_FLOOD;
         end
         S_FLOOD: begin
            if (any_hit) begin
               len_in   = 6'(lvl_ff);
               trk_in   = lvl_next;
               n_in     = '0;
               dir_in   = gwr_pkg::DIR_MINUS_X;
               state_in = S_TRACE;
            end else if (!any_grew) begin
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
            end else begin
               lvl_in = lvl_next;
            end
         end
         S_TRACE: begin
            dir_in = dir_ff + 2'd1;
            if (any_match) begin
               rsp_strobe_in           = 1'b1;
               rsp_word_in.reachable   = 1'b1;
               rsp_word_in.path_length = len_ff;
               rsp_word_in.step_dir    = dir_ff;
               rsp_word_in.last        = step_last;
               trk_in = dist_prev;
               n_in   = n_ff + 6'd1;
               if (step_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
         dir_ff        <= gwr_pkg::DIR_MINUS_X;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         dir_ff        <= dir_in;
      end
      lvl_ff      <= lvl_in;
      trk_ff      <= trk_in;
      len_ff      <= len_in;
      n_ff        <= n_in;
      rsp_word_ff <= rsp_word_in;
      if (accept) begin
         sx_ff <= req_word.start_x;
         sy_ff <= req_word.start_y;
         gx_ff <= req_word.goal_x;
         gy_ff <= req_word.goal_y;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

endmodule
`default_nettype wire

// ----- sim/grid_wavefront_router_unit_tb.sv -----
// Testbench for the grid wavefront router: queued words, self-checking route predictor.
`timescale 1ns / 100ps
`default_nettype none
module grid_wavefront_router_unit_tb;

   localparam int N = 8;
   localparam int STALL_LIMIT = 2000;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   gwr_pkg::req_word_type req_word;
   logic rsp_strobe;
   gwr_pkg::rsp_word_type rsp_word;

   grid_wavefront_router_unit u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_word(req_word), .rsp_strobe(rsp_strobe), .rsp_word(rsp_word)
   );

   logic occ [N*N];
   gwr_pkg::rsp_word_type route_due [$];
   gwr_pkg::req_word_type word_queue [$];
   int gap_queue [$];
   int drain_mark [$];
   int errors;
   int idle_cycles;
   int wait_left;
   bit feeding_done;
   int sent;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic gwr_pkg::req_word_type mk_write(int x, int y, int f);
      gwr_pkg::req_word_type w;
      w = '0;
      w.kind = gwr_pkg::KIND_WRITE;
      w.cell_x = 3'(x);
      w.cell_y = 3'(y);
      w.cell_full = 1'(f);
      w.start_x = 3'($urandom);
      w.start_y = 3'($urandom);
      w.goal_x = 3'($urandom);
      w.goal_y = 3'($urandom);
      return w;
   endfunction

   function automatic gwr_pkg::req_word_type mk_route(int sx, int sy, int gx, int gy);
      gwr_pkg::req_word_type w;
      w = '0;
      w.kind = gwr_pkg::KIND_ROUTE;
      w.cell_x = 3'($urandom);
      w.cell_y = 3'($urandom);
      w.cell_full = 1'($urandom);
      w.start_x = 3'(sx);
      w.start_y = 3'(sy);
      w.goal_x = 3'(gx);
      w.goal_y = 3'(gy);
      return w;
   endfunction

   function automatic bit step_cell(int x, int y, int d, output int nx, output int ny);
      nx = x;
      ny = y;
      case (d)
         gwr_pkg::DIR_MINUS_X: begin
            if (x == 0) return 0;
            nx = x - 1;
         end
         gwr_pkg::DIR_PLUS_X: begin
            if (x + 1 >= N) return 0;
            nx = x + 1;
         end
         gwr_pkg::DIR_MINUS_Y: begin
            if (y == 0) return 0;
            ny = y - 1;
         end
         default: begin
            if (y + 1 >= N) return 0;
            ny = y + 1;
         end
      endcase
      return 1;
   endfunction

   task automatic predict_route(gwr_pkg::req_word_type w);
      int wave [N*N];
      bit blk [N*N];
      int sx, sy, gx, gy, k, x, y, d, nx, ny, len, n, guard, dir;
      gwr_pkg::rsp_word_type r;
      gwr_pkg::rsp_word_type steps [$];
      sx = w.start_x;
      sy = w.start_y;
      gx = w.goal_x;
      gy = w.goal_y;
      for (int i = 0; i < N*N; i++) begin
         wave[i] = 0;
         blk[i] = occ[i];
      end
      wave[gx*N+gy] = 1;
      blk[sx*N+sy] = 0;
      wave[sx*N+sy] = 0;
      for (k = 1; k <= N*N; k++)
         for (x = 0; x < N; x++)
            for (y = 0; y < N; y++)
               if (wave[x*N+y] == k)
                  for (d = 0; d < 4; d++)
                     if (step_cell(x, y, d, nx, ny) && !blk[nx*N+ny] && wave[nx*N+ny] == 0)
                        wave[nx*N+ny] = k + 1;
      k = wave[sx*N+sy];
      n = 0;
      if (k != 0) begin
         len = k - 1;
         x = sx;
         y = sy;
         dir = 0;
         for (guard = 0; k > 1 && n < gwr_pkg::MAX_RESULTS && guard < 4*N*N; guard++) begin
            d = dir;
            if (step_cell(x, y, d, nx, ny) && wave[nx*N+ny] == k - 1) begin
               r.reachable = 1'b1;
               r.path_length = 6'(len);
               r.step_dir = 2'(d);
               r.last = 1'b0;
               steps.push_back(r);
               n++;
               x = nx;
               y = ny;
               k--;
            end
            dir = (d + 1) % 4;
         end
      end
      if (n == 0) begin
         r = '0;
         r.last = 1'b1;
         route_due.push_back(r);
      end else begin
         steps[n-1].last = 1'b1;
         foreach (steps[i]) route_due.push_back(steps[i]);
         occ[sx*N+sy] = 1'b0;
         occ[gx*N+gy] = 1'b1;
      end
   endtask

   task automatic predict_word(gwr_pkg::req_word_type w);
      if (w.kind == gwr_pkg::KIND_WRITE) occ[w.cell_x*N+w.cell_y] = w.cell_full;
      else predict_route(w);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_word <= '0;
         wait_left <= 0;
         sent <= 0;
      end else if (start && !busy) begin
         predict_word(req_word);
         start <= 1'b0;
         sent <= sent + 1;
         wait_left <= gap_queue.size() ? gap_queue.pop_front() : 0;
      end else if (!start && word_queue.size() != 0) begin
         if (wait_left > 0) begin
            wait_left <= wait_left - 1;
         end else if (drain_mark.size() != 0 && drain_mark[0] == sent) begin
            if (route_due.size() == 0 && !busy) void'(drain_mark.pop_front());
         end else begin
            req_word <= word_queue.pop_front();
            start <= 1'b1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (route_due.size() == 0) begin
            $error("unexpected result word %h", rsp_word);
            errors++;
         end else begin
            gwr_pkg::rsp_word_type e;
            e = route_due.pop_front();
            if (rsp_word.reachable !== e.reachable) begin
               $error("reachable exp %0d got %0d", e.reachable, rsp_word.reachable);
               errors++;
            end
            if (rsp_word.path_length !== e.path_length) begin
               $error("path_length exp %0d got %0d", e.path_length, rsp_word.path_length);
               errors++;
            end
            if (rsp_word.step_dir !== e.step_dir) begin
               $error("step_dir exp %0d got %0d", e.step_dir, rsp_word.step_dir);
               errors++;
            end
            if (rsp_word.last !== e.last) begin
               $error("last exp %0d got %0d", e.last, rsp_word.last);
               errors++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || rsp_strobe || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic push_word(gwr_pkg::req_word_type w);
      word_queue.push_back(w);
      gap_queue.push_back(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16));
   endtask

   initial begin
      int x, y, items, mode;
      errors = 0;
      idle_cycles = 0;
      foreach (occ[i]) occ[i] = 1'b0;
      start = 1'b0;
      req_word = '0;
      reset = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      push_word(mk_route(0, 0, 7, 7));
      push_word(mk_route(7, 7, 0, 0));
      push_word(mk_route(3, 3, 3, 3));
      push_word(mk_write(7, 0, 1));
      push_word(mk_write(0, 7, 0));
      push_word(mk_route(0, 7, 7, 0));
      push_word(mk_route(2, 2, 2, 3));
      for (y = 0; y < N; y++) push_word(mk_write(4, y, 1));
      push_word(mk_route(0, 0, 7, 0));
      push_word(mk_route(4, 4, 0, 4));
      push_word(mk_write(4, 6, 0));
      push_word(mk_route(0, 0, 7, 7));
      push_word(mk_route(5, 5, 4, 3));
      drain_mark.push_back(20);

      items = 0;
      while (items < 310) begin
         mode = $urandom_range(0, 9);
         if (mode < 4) begin
            push_word(mk_write($urandom, $urandom, $urandom_range(0, 3) == 0));
         end else if (mode == 4) begin
            for (x = 0; x < N; x++) push_word(mk_write(x, $urandom, 0));
            items += N - 1;
         end else begin
            push_word(mk_route($urandom, $urandom, $urandom, $urandom));
         end
         items++;
         if (items % 100 == 0) drain_mark.push_back(20 + items);
      end

      while (word_queue.size() != 0 || start) @(posedge clock);
      while (route_due.size() != 0 || busy) @(posedge clock);
      repeat (300) @(posedge clock);
      if (errors == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end
endmodule
`default_nettype wire

// ----- filelist.f -----
rtl/gwr_pkg.sv
rtl/gwr_cell.sv
rtl/grid_wavefront_router_unit.sv
sim/grid_wavefront_router_unit_tb.sv
